>>> hw/rtl/ghb_pkg.sv
`default_nettype none
package ghb_pkg;

  localparam int unsigned COUNT_BITS    = 20;
  localparam int unsigned NUM_BINS      = 256;
  localparam int unsigned BIN_BITS      = $clog2(NUM_BINS);
  localparam int unsigned ROW_BITS      = 12;
  localparam int unsigned HEIGHT_BITS   = 13;
  localparam int unsigned PIX_BITS      = 8;
  localparam int unsigned PROD_BITS     = HEIGHT_BITS + COUNT_BITS;
  localparam int unsigned STEP_BITS     = $clog2(PROD_BITS + 1);
  localparam int unsigned IN_DATA_BITS  = 32;
  localparam int unsigned OUT_DATA_BITS = 48;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_BITS-1:0]  COUNT_MAX     = {COUNT_BITS{1'b1}};
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET  = HEIGHT_BITS'(256);
  localparam logic [PIX_BITS-1:0]    PIX_BAR       = PIX_BITS'(0);
  localparam logic [PIX_BITS-1:0]    PIX_BACKGROUND = PIX_BITS'(255);

  typedef enum logic [1:0] {
    ACT_COUNT = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2
  } ghb_action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_QUERY,
    ST_START,
    ST_DIV,
    ST_OUT
  } ghb_state_e;

  typedef struct packed {
    ghb_action_e           action;
    logic [BIN_BITS-1:0]   bin;
    logic [ROW_BITS-1:0]   row;
  } ghb_item_t;

endpackage
`default_nettype wire

>>> hw/rtl/ghb_front.sv
`default_nettype none
module ghb_front
  import ghb_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [IN_DATA_BITS-1:0] s_axis_tdata,
  input  wire logic [1:0]              s_axis_tuser,
  output logic                         q_valid_o,
  output ghb_item_t                    q_item_o,
  input  wire logic                    q_pop_i
);

  ghb_item_t            queue_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wptr_q, rptr_q;
  logic [QCNT_BITS-1:0] cnt_q;
  ghb_item_t            item;
  logic                 push, pop, known;

  // pick the bin field by action; unused code is dropped here
  always_comb begin
    item.action = ghb_action_e'(s_axis_tuser);
    item.row    = s_axis_tdata[16 +: ROW_BITS];
    item.bin    = s_axis_tdata[0 +: BIN_BITS];
    known       = 1'b1;
    case (s_axis_tuser)
      ACT_COUNT: item.bin = s_axis_tdata[0 +: BIN_BITS];
      ACT_QUERY: item.bin = s_axis_tdata[8 +: BIN_BITS];
      ACT_CLEAR: item.bin = s_axis_tdata[0 +: BIN_BITS];
      default:   known    = 1'b0;
    endcase
  end

  assign s_axis_tready = (cnt_q != QCNT_BITS'(QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready && known;
  assign q_valid_o     = (cnt_q != '0);
  assign pop           = q_pop_i && q_valid_o;
  assign q_item_o      = queue_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ghb_div.sv
`default_nettype none
module ghb_div
  import ghb_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [PROD_BITS-1:0]   dividend_i,
  input  wire logic [COUNT_BITS-1:0]  divisor_i,
  output logic                        done_o,
  output logic [PROD_BITS-1:0]        quotient_o
);

  logic [PROD_BITS-1:0]  quo_q;
  logic [COUNT_BITS-1:0] rem_q, dsr_q;
  logic [STEP_BITS-1:0]  step_q;
  logic                  busy_q, done_q;
  logic [COUNT_BITS:0]   rem_shift, diff;
  logic                  fits;

  // restoring division, one quotient bit a cycle
  assign rem_shift = {rem_q, quo_q[PROD_BITS-1]};
  assign diff      = rem_shift - {1'b0, dsr_q};
  assign fits      = (rem_shift >= {1'b0, dsr_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[PROD_BITS-2:0], fits};
      rem_q <= fits ? diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_BITS'(PROD_BITS);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_BITS'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

>>> hw/rtl/ghb_back.sv
`default_nettype none
module ghb_back
  import ghb_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [HEIGHT_BITS-1:0]   cfg_wdata_i,
  input  wire logic                     q_valid_i,
  input  wire ghb_item_t                q_item_i,
  output logic                          q_pop_o,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic [OUT_DATA_BITS-1:0]      m_axis_tdata
);

  ghb_state_e state_q, state_d;

  logic [COUNT_BITS-1:0]  mem [NUM_BINS];
  logic [NUM_BINS-1:0]    valid_q;
  logic [COUNT_BITS-1:0]  rdata_q;
  logic                   rvalid_q;
  logic [BIN_BITS-1:0]    raddr;

  logic [HEIGHT_BITS-1:0] height_q, h_q, bar_q;
  logic [ROW_BITS-1:0]    row_q;
  logic [BIN_BITS-1:0]    bin_q;
  logic [COUNT_BITS-1:0]  peak_q, count_q, cur, inc;
  logic [PROD_BITS-1:0]   prod_q, quo;
  logic                   out_valid_q;
  logic                   mem_we, clear, div_start, div_done, latch_item, load_out;
  logic                   bar_zero, set_bar;
  logic [HEIGHT_BITS-1:0] from_bottom, bar_d;
  logic [PIX_BITS-1:0]    pix;

  assign raddr = q_item_i.bin;
  assign cur   = rvalid_q ? rdata_q : '0;
  assign inc   = (cur == COUNT_MAX) ? cur : cur + 1'b1;

  always_comb begin
    state_d    = state_q;
    q_pop_o    = 1'b0;
    mem_we     = 1'b0;
    clear      = 1'b0;
    div_start  = 1'b0;
    latch_item = 1'b0;
    load_out   = 1'b0;
    bar_zero   = 1'b0;
    set_bar    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        q_pop_o = q_valid_i;
        if (q_valid_i) begin
          latch_item = 1'b1;
          case (q_item_i.action)
            ACT_COUNT: state_d = ST_COUNT;
            ACT_QUERY: state_d = ST_QUERY;
            default:   clear   = 1'b1;
          endcase
        end
      end
      ST_COUNT: begin
        mem_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_QUERY: state_d = ST_START;
      ST_START: begin
        if (peak_q == '0) begin
          bar_zero = 1'b1;
          state_d  = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          set_bar = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // bin store, read data registered
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[bin_q] <= inc;
    end
    rdata_q <= mem[raddr];
  end

  // a bin whose flag is low reads as zero, so clear needs no pass over the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
      peak_q   <= '0;
      height_q <= HEIGHT_RESET;
    end else begin
      rvalid_q <= valid_q[raddr];
      if (clear) begin
        valid_q <= '0;
        peak_q  <= '0;
      end else if (mem_we) begin
        valid_q[bin_q] <= 1'b1;
        if (inc > peak_q) begin
          peak_q <= inc;
        end
      end
      if (cfg_we_i) begin
        height_q <= cfg_wdata_i;
      end
    end
  end

  ghb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (peak_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign bar_d = (quo > PROD_BITS'(h_q)) ? h_q : quo[HEIGHT_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (latch_item) begin
      bin_q <= q_item_i.bin;
      row_q <= q_item_i.row;
      h_q   <= height_q;
    end
    if (state_q == ST_QUERY) begin
      count_q <= cur;
      prod_q  <= PROD_BITS'(h_q) * PROD_BITS'(cur);
    end
    if (bar_zero) begin
      bar_q <= '0;
    end else if (set_bar) begin
      bar_q <= bar_d;
    end
  end

  // chart pixel: row counted from the bottom against the bar
  assign from_bottom = h_q - 1'b1 - HEIGHT_BITS'(row_q);
  assign pix = (HEIGHT_BITS'(row_q) >= h_q) ? PIX_BACKGROUND :
               (from_bottom < bar_q)        ? PIX_BAR : PIX_BACKGROUND;

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_axis_tdata <= OUT_DATA_BITS'({pix, bar_q, count_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;

endmodule
`default_nettype wire

>>> hw/rtl/gray_histogram_bar_chart_unit.sv
// 256-bin gray-level histogram with a bar-chart readout.
// input stream: s_axis_tuser carries the action (count, query, clear), s_axis_tdata
// the pixel, column and row. a query gives one transfer on the output stream with
// the bin count, the scaled bar height and the chart pixel; count and clear give
// none, and action code 3 is dropped on entry.
// a two-entry queue sits between the input side and the histogram engine, so the
// input keeps taking transfers while the engine works or the output stalls.
// engine steps per item: count reads then writes the bin store; clear drops the
// per-bin valid flags at once; query reads, multiplies, runs a 33-step restoring
// division by the peak and then loads the output register, and when the peak is
// zero the division is skipped.
// chart_height is written through cfg_we_i/cfg_wdata_i, by the user only while idle;
// the block does not enforce this. reset value 256. reset clears all bins, the peak
// and the queue and sets the height to 256; no clearing pass is needed.
// when the receiver holds m_axis_tready low the result waits in the output
// register, the engine holds in front of it, and the queue fills and then stalls
// the input.
`default_nettype none
module gray_histogram_bar_chart_unit
  import ghb_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [HEIGHT_BITS-1:0]   cfg_wdata_i,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // pixel_value [7:0], column [15:8], row [27:16], zero [31:28]
  input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // action [1:0]
  input  wire logic [1:0]               s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // bin_count [19:0], bar_height [32:20], pixel_out [40:33], zero [47:41]
  output logic [OUT_DATA_BITS-1:0]      m_axis_tdata
);

  logic      q_valid, q_pop;
  ghb_item_t q_item;

  ghb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  ghb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire
